@@ rtl/huffman_codebook_bit_decoder_top_macros.svh @@
// Assertion helpers for the checker file.
`ifndef HUFFMAN_CODEBOOK_BIT_DECODER_TOP_MACROS_SVH
`define HUFFMAN_CODEBOOK_BIT_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/hcbd_pkg.sv @@
package hcbd_pkg;

	localparam int CODE_W = 32;
	localparam int LEN_W  = 6;
	localparam int SYM_W  = 16;
	localparam int SLOT_W = 8;
	localparam int BYTE_W = 8;
	localparam int ACT_W  = 2;
	localparam int EIU_W  = 9;

	localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_BYTE    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

	typedef struct packed {
		logic [CODE_W-1:0] code_word;
		logic [LEN_W-1:0]  code_length;
		logic [SYM_W-1:0]  entry_number;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

@@ rtl/hcbd_in_if.sv @@
interface hcbd_in_if
	import hcbd_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [SLOT_W-1:0] entry_slot;
	logic [CODE_W-1:0] code_word;
	logic [LEN_W-1:0]  code_length;
	logic [SYM_W-1:0]  entry_number;
	logic [BYTE_W-1:0] stream_byte;

	modport source (
		output valid, action, entry_slot, code_word, code_length, entry_number, stream_byte,
		input  ready
	);
	modport sink (
		input  valid, action, entry_slot, code_word, code_length, entry_number, stream_byte,
		output ready
	);
endinterface

@@ rtl/hcbd_out_if.sv @@
interface hcbd_out_if
	import hcbd_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             decode_error;
	logic             last;

	modport source (
		output valid, symbol, decode_error, last,
		input  ready
	);
	modport sink (
		input  valid, symbol, decode_error, last,
		output ready
	);
endinterface

@@ rtl/hcbd_ram.sv @@
module hcbd_ram #(
	parameter int WIDTH = 54,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/hcbd_cell.sv @@
module hcbd_cell
	import hcbd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       bit_in,
	input  logic       ref_bit,
	input  logic       match_in,
	output logic       bit_q,
	output logic       match_out
);

	// One bit of the accumulated codeword; it takes its neighbor's bit on a shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (ctrl.clear) begin
			bit_q <= 1'b0;
		end else if (ctrl.shift) begin
			bit_q <= bit_in;
		end
	end

	assign match_out = match_in && (bit_q == ref_bit);

endmodule

@@ rtl/huffman_codebook_bit_decoder_top.sv @@
// Steps: each bit of a byte passes ST_BIT and ST_NEXT, each table read a read and a check state
// (leading unused, current-length and walk-ending entries), and each result ST_RES.
// Throughput: one request at a time; ready is high only while no byte is in work, and a
// byte holds the input until its last result is registered, so output stalls delay it.
// Reset (arst_n low, asynchronous) clears the codeword, length, scan pointer,
// entries_in_use and the output register; the code table keeps no reset.
module huffman_codebook_bit_decoder_top
	import hcbd_pkg::*;
#(
	parameter int TABLE_DEPTH     = 256,
	parameter int MAX_CODE_LENGTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [EIU_W-1:0] cfg_wr_data,
	hcbd_in_if.sink          in_ch,
	hcbd_out_if.source       out_ch
);

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int PTR_W  = $clog2(TABLE_DEPTH + 1);
	localparam int CNT_W  = (PTR_W > EIU_W) ? PTR_W : EIU_W;
	localparam int PLEN_W = $clog2(MAX_CODE_LENGTH + 1);
	localparam int BCNT_W = $clog2(BYTE_W);
	localparam logic [CODE_W-1:0] CW_MASK =
		CODE_W'((64'd1 << MAX_CODE_LENGTH) - 64'd1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIT,
		ST_SKIP_RD,
		ST_SKIP_CHK,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_RES,
		ST_NEXT
	} state_t;

	state_t              state_q;
	logic [EIU_W-1:0]    eiu_q;
	logic [PTR_W-1:0]    ptr_q;
	logic [PLEN_W-1:0]   plen_q;
	logic [BCNT_W-1:0]   bit_cnt_q;
	logic [BYTE_W-1:0]   byte_q;
	logic [SYM_W-1:0]    res_sym_q;
	logic                res_err_q;
	logic                pend_valid_q;
	logic [SYM_W-1:0]    pend_sym_q;
	logic                pend_err_q;
	logic                out_valid_q;
	logic [SYM_W-1:0]    out_sym_q;
	logic                out_err_q;
	logic                out_last_q;

	entry_t              wr_entry;
	entry_t              rd_entry;
	logic [CNT_W-1:0]    slot_x;
	logic [CNT_W-1:0]    eiu_x;
	logic [CNT_W-1:0]    n_x;
	logic [PTR_W-1:0]    n_cnt;
	logic                in_fire;
	logic                slot_ok;
	logic                ram_we;
	logic                ptr_lt_n;
	logic                len_eq;
	logic                plen_at_max;
	logic                cw_match;
	logic                skip_more;
	logic                scan_hit;
	logic                scan_err;
	logic                out_free;
	logic                out_load;
	logic                byte_done;
	cell_ctrl_t          cell_ctrl;
	logic [MAX_CODE_LENGTH-1:0] code_bits;
	logic [MAX_CODE_LENGTH:0]   match_chain;

	assign in_fire = in_ch.valid && in_ch.ready;
	assign slot_x  = CNT_W'(in_ch.entry_slot);
	assign slot_ok = slot_x < CNT_W'(TABLE_DEPTH);
	assign ram_we  = in_fire && (in_ch.action == ACT_LOAD) && slot_ok;

	assign wr_entry.code_word    = in_ch.code_word;
	assign wr_entry.code_length  = in_ch.code_length;
	assign wr_entry.entry_number = in_ch.entry_number;

	hcbd_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_x[ADDR_W-1:0]),
		.wdata (wr_entry),
		.raddr (ptr_q[ADDR_W-1:0]),
		.rdata (rd_entry)
	);

	// Searched entries are capped at the table depth.
	assign eiu_x    = CNT_W'(eiu_q);
	assign n_x      = (eiu_x > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : eiu_x;
	assign n_cnt    = n_x[PTR_W-1:0];
	assign ptr_lt_n = ptr_q < n_cnt;

	assign len_eq      = rd_entry.code_length == LEN_W'(plen_q);
	assign plen_at_max = plen_q >= PLEN_W'(MAX_CODE_LENGTH);
	assign skip_more   = ptr_lt_n && (rd_entry.code_length == '0);

	// The accumulated codeword lives in a row of cells; the compare ripples along it.
	// Stored bits above the longest length must be zero, as the row never holds them.
	assign match_chain[0] = 1'b1;
	for (genvar i = 0; i < MAX_CODE_LENGTH; i++) begin : g_cell
		hcbd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl),
			.bit_in    ((i == 0) ? byte_q[0] : code_bits[(i == 0) ? 0 : i - 1]),
			.ref_bit   (rd_entry.code_word[i]),
			.match_in  (match_chain[i]),
			.bit_q     (code_bits[i]),
			.match_out (match_chain[i+1])
		);
	end
	assign cw_match = match_chain[MAX_CODE_LENGTH] && ((rd_entry.code_word & ~CW_MASK) == '0);

	assign scan_hit = (state_q == ST_SCAN_CHK) && ptr_lt_n && len_eq && cw_match;
	assign scan_err = (state_q == ST_SCAN_CHK) && !(ptr_lt_n && len_eq) &&
		(!ptr_lt_n || plen_at_max);

	assign cell_ctrl.shift = ((state_q == ST_BIT) && (plen_q != '0)) ||
		((state_q == ST_SKIP_CHK) && !skip_more);
	assign cell_ctrl.clear = (in_fire && (in_ch.action == ACT_RESTART)) || scan_hit || scan_err;

	assign out_free  = !out_valid_q || out_ch.ready;
	assign byte_done = bit_cnt_q == BCNT_W'(BYTE_W - 1);
	// The output register takes the pending result either when a newer one arrives
	// or when the byte runs out.
	assign out_load  = pend_valid_q && out_free &&
		((state_q == ST_RES) || ((state_q == ST_NEXT) && byte_done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			eiu_q        <= '0;
			ptr_q        <= '0;
			plen_q       <= '0;
			bit_cnt_q    <= '0;
			byte_q       <= '0;
			res_sym_q    <= '0;
			res_err_q    <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_sym_q   <= '0;
			pend_err_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			out_sym_q    <= '0;
			out_err_q    <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				eiu_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (in_ch.action)
							ACT_BYTE: begin
								byte_q    <= in_ch.stream_byte;
								bit_cnt_q <= '0;
								state_q   <= ST_BIT;
							end
							ACT_RESTART: begin
								ptr_q  <= '0;
								plen_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_BIT: begin
					if (plen_q == '0) begin
						state_q <= ST_SKIP_RD;
					end else begin
						plen_q  <= plen_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SKIP_RD: begin
					state_q <= ST_SKIP_CHK;
				end
				ST_SKIP_CHK: begin
					if (skip_more) begin
						ptr_q   <= ptr_q + 1'b1;
						state_q <= ST_SKIP_RD;
					end else begin
						plen_q  <= plen_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CHK;
				end
				ST_SCAN_CHK: begin
					if (scan_hit || scan_err) begin
						res_sym_q <= scan_hit ? rd_entry.entry_number : '0;
						res_err_q <= scan_err;
						ptr_q     <= '0;
						plen_q    <= '0;
						state_q   <= ST_RES;
					end else if (ptr_lt_n && len_eq) begin
						ptr_q   <= ptr_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end else begin
						state_q <= ST_NEXT;
					end
				end
				ST_RES: begin
					// A result is held back one place so that the last one of a byte
					// can be flagged when the byte runs out.
					if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							out_sym_q  <= pend_sym_q;
							out_err_q  <= pend_err_q;
							out_last_q <= 1'b0;
						end
						pend_valid_q <= 1'b1;
						pend_sym_q   <= res_sym_q;
						pend_err_q   <= res_err_q;
						state_q      <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (!byte_done) begin
						bit_cnt_q <= bit_cnt_q + 1'b1;
						byte_q    <= byte_q >> 1;
						state_q   <= ST_BIT;
					end else if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_sym_q    <= pend_sym_q;
						out_err_q    <= pend_err_q;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ch.ready         = state_q == ST_IDLE;
	assign out_ch.valid        = out_valid_q;
	assign out_ch.symbol       = out_sym_q;
	assign out_ch.decode_error = out_err_q;
	assign out_ch.last         = out_last_q;

endmodule

@@ rtl/hcbd_checker.sv @@
`include "huffman_codebook_bit_decoder_top_macros.svh"

module hcbd_checker
	import hcbd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [ACT_W-1:0] in_action,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [SYM_W-1:0] out_symbol,
	input  logic             out_decode_error,
	input  logic             out_last
);

	// A result that waits keeps its place.
	`HCBD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// A waiting result keeps its fields.
	`HCBD_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_symbol) && $stable(out_decode_error) && $stable(out_last), "result changed while stalled")

	// An error result always carries symbol zero.
	`HCBD_ASSERT_NOW(a_err_sym, clk, arst_n, out_valid && out_decode_error, out_symbol == '0, "error result with nonzero symbol")

	// An accepted byte keeps the decoder busy for at least the next cycle.
	`HCBD_ASSERT_NEXT(a_byte_busy, clk, arst_n, in_valid && in_ready && (in_action == ACT_BYTE), !in_ready, "new request taken while a byte is in work")

endmodule

bind huffman_codebook_bit_decoder_top hcbd_checker u_hcbd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_ch.valid),
	.in_ready         (in_ch.ready),
	.in_action        (in_ch.action),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.out_symbol       (out_ch.symbol),
	.out_decode_error (out_ch.decode_error),
	.out_last         (out_ch.last)
);
